[sv/rgb_to_hsl_converter_defines.svh]
// assertion macros shared by the rgb to hsl converter
`ifndef RGB_TO_HSL_CONVERTER_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_DEFINES_SVH

// implication checked at every clock edge outside reset
`define RHC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rhc check failed");

// condition that holds at every clock edge outside reset
`define RHC_ASSERT_ALWAYS(label, cons) \
	`RHC_ASSERT_IMPL(label, 1'b1, cons)

`endif

[sv/rhc_pkg.sv]
// shared constants, widths and the divider step for the rgb to hsl converter
package rhc_pkg;

	// channel and field widths
	localparam int CH_W      = 8;
	localparam int FIELD_W   = 15;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 48;

	// divider shape: 23-bit dividend, 8-bit divisor, 15-bit quotient
	localparam int NUM_W      = 23;
	localparam int DEN_W      = 8;
	localparam int QUO_W      = 15;
	localparam int STEPS      = 3;
	localparam int DIV_STAGES = QUO_W / STEPS;

	// hue sextant numerator width (up to six times the channel spread)
	localparam int N_W = 11;

	// fixed-point scale factors
	localparam int HUE_SCALE   = 3840;
	localparam int SAT_SCALE   = 25600;
	localparam int LIGHT_DIV   = 255;
	localparam int SUM_FULL    = 510;

	// lightness by reciprocal multiplication: floor(sum * LIGHT_RECIP / 2^17)
	// equals floor(12800 * sum / 255) for every sum up to 510
	localparam int LIGHT_RECIP  = 6579301;
	localparam int LIGHT_SHIFT  = 17;
	localparam int LIGHT_PROD_W = 32;

	// one restoring division step: shift in the next dividend bit, trial subtract
	function automatic logic [NUM_W-1:0] div_step(input logic [NUM_W-1:0] w,
			input logic [DEN_W-1:0] den);
		logic [DEN_W:0]   t;
		logic [DEN_W:0]   diff;
		logic             qb;
		logic [DEN_W-1:0] rem;
		t    = w[NUM_W-1 -: DEN_W+1];
		diff = t - {1'b0, den};
		qb   = (t >= {1'b0, den});
		rem  = qb ? diff[DEN_W-1:0] : t[DEN_W-1:0];
		return {rem, w[QUO_W-2:0], qb};
	endfunction

endpackage

[sv/rhc_div.sv]
// pipelined restoring divider, three quotient bits per stage
module rhc_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rhc_pkg::NUM_W-1:0]  num,
	input  logic [rhc_pkg::DEN_W-1:0]  den,
	output logic [rhc_pkg::QUO_W-1:0]  quo
);
	import rhc_pkg::*;

	logic [NUM_W-1:0] work_s [DIV_STAGES+1];
	logic [DEN_W-1:0] den_s  [DIV_STAGES+1];

	// stage zero is the raw dividend; the upper bits are the first partial remainder
	assign work_s[0] = num;
	assign den_s[0]  = den;

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		logic [NUM_W-1:0] work_nx;

		// a few dependent trial subtractions per stage
		always_comb begin
			work_nx = work_s[i];
			for (int k = 0; k < STEPS; k++) begin
				work_nx = div_step(work_nx, den_s[i]);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				work_s[i+1] <= work_nx;
				den_s[i+1]  <= den_s[i];
			end
		end
	end

	// quotient has shifted fully into the low bits
	assign quo = work_s[DIV_STAGES][QUO_W-1:0];

endmodule

[sv/rgb_to_hsl_converter.sv]
// Converts a stream of 8-bit RGB pixels to hue (1/64 degree), saturation and
// lightness (1/256 percent), all truncated. One pixel is accepted every clock
// cycle while the output side takes results. From input handshake to valid
// result it passes in order: one stage finds the largest and smallest
// channel, one forms the scaled numerators and divisors and the lightness by a
// reciprocal multiplication, and five stages of three restoring-division steps
// each produce the hue and saturation quotients while the lightness rides along.
// The output stage is the last divider register; when the sink stalls, the
// whole pipeline holds.
`include "rgb_to_hsl_converter_defines.svh"

module rgb_to_hsl_converter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// red [7:0], green [15:8], blue [23:16]
	input  logic [rhc_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// hue [14:0], saturation [29:15], lightness [44:30], zero [47:45]
	output logic [rhc_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import rhc_pkg::*;

	logic en;

	logic [CH_W-1:0] red, green, blue;
	logic [CH_W-1:0] mx, mn;
	logic            red_max, green_max;

	logic [CH_W-1:0] r_s1, g_s1, b_s1, d_s1;
	logic [CH_W:0]   sum_s1;
	logic            red_max_s1, green_max_s1;
	logic            vld_s1, vld_s2;

	logic [N_W-1:0]   d_n, hue_n;
	logic [CH_W:0]    sat_den_wide;
	logic [NUM_W-1:0] hue_num_s2, sat_num_s2;
	logic [DEN_W-1:0] hue_den_s2, sat_den_s2;

	logic [LIGHT_PROD_W-1:0] light_prod;
	logic [QUO_W-1:0]        light_s2;
	logic [QUO_W-1:0]        light_pipe_s [DIV_STAGES];

	logic [DIV_STAGES-1:0] div_vld_s;
	logic [QUO_W-1:0]      hue_q, sat_q, light_q;

	// pipeline advances whenever the output register is free or being taken
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	assign red   = s_tdata[CH_W-1:0];
	assign green = s_tdata[2*CH_W-1:CH_W];
	assign blue  = s_tdata[3*CH_W-1:2*CH_W];

	// largest and smallest channel, red wins ties over green, green over blue
	always_comb begin
		red_max   = (red >= green) && (red >= blue);
		green_max = !red_max && (green >= blue);
		if (red_max)
			mx = red;
		else if (green_max)
			mx = green;
		else
			mx = blue;
		mn = red;
		if (green < mn)
			mn = green;
		if (blue < mn)
			mn = blue;
	end

	// stage 1: spread and sum
	always_ff @(posedge clk) begin
		if (en) begin
			r_s1         <= red;
			g_s1         <= green;
			b_s1         <= blue;
			d_s1         <= mx - mn;
			sum_s1       <= {1'b0, mx} + {1'b0, mn};
			red_max_s1   <= red_max;
			green_max_s1 <= green_max;
		end
	end

	// hue sextant numerator, modular arithmetic is exact since the result is in range
	always_comb begin
		d_n = N_W'(d_s1);
		if (red_max_s1) begin
			hue_n = N_W'(g_s1) - N_W'(b_s1);
			if (g_s1 < b_s1)
				hue_n = hue_n + (d_n << 2) + (d_n << 1);
		end else if (green_max_s1) begin
			hue_n = N_W'(b_s1) - N_W'(r_s1) + (d_n << 1);
		end else begin
			hue_n = N_W'(r_s1) - N_W'(g_s1) + (d_n << 2);
		end
	end

	// saturation divisor: 255 - |sum - 255|
	assign sat_den_wide = (sum_s1 >= (CH_W+1)'(LIGHT_DIV)) ?
		(CH_W+1)'(SUM_FULL) - sum_s1 : sum_s1;

	// lightness: scaled sum divided by 255 through a reciprocal
	assign light_prod = LIGHT_PROD_W'(sum_s1) * LIGHT_PROD_W'(LIGHT_RECIP);

	// stage 2: scaled dividends and divisors, grey pixels divide zero by one
	always_ff @(posedge clk) begin
		if (en) begin
			if (d_s1 == '0) begin
				hue_num_s2 <= '0;
				hue_den_s2 <= DEN_W'(1);
				sat_num_s2 <= '0;
				sat_den_s2 <= DEN_W'(1);
			end else begin
				hue_num_s2 <= NUM_W'(hue_n) * NUM_W'(HUE_SCALE);
				hue_den_s2 <= d_s1;
				sat_num_s2 <= NUM_W'(d_s1) * NUM_W'(SAT_SCALE);
				sat_den_s2 <= sat_den_wide[DEN_W-1:0];
			end
			light_s2 <= light_prod[LIGHT_SHIFT +: QUO_W];
		end
	end

	// lightness delay matching the divider stages
	always_ff @(posedge clk) begin
		if (en) begin
			light_pipe_s[0] <= light_s2;
			for (int i = 1; i < DIV_STAGES; i++)
				light_pipe_s[i] <= light_pipe_s[i-1];
		end
	end

	// valid bits follow the data through every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			div_vld_s <= '0;
		end else if (en) begin
			vld_s1    <= s_tvalid;
			vld_s2    <= vld_s1;
			div_vld_s <= {div_vld_s[DIV_STAGES-2:0], vld_s2};
		end
	end

	// two dividers share one pipeline shape
	rhc_div u_hue_div (
		.clk (clk),
		.en  (en),
		.num (hue_num_s2),
		.den (hue_den_s2),
		.quo (hue_q)
	);

	rhc_div u_sat_div (
		.clk (clk),
		.en  (en),
		.num (sat_num_s2),
		.den (sat_den_s2),
		.quo (sat_q)
	);

	// result packing
	assign light_q  = light_pipe_s[DIV_STAGES-1];
	assign m_tvalid = div_vld_s[DIV_STAGES-1];
	assign m_tdata  = {(OUT_DATA_W - 3*FIELD_W)'(0), light_q, sat_q, hue_q};

	// the first partial remainder must stay below the divisor
	`RHC_ASSERT_ALWAYS(a_hue_div_range, !vld_s2 || (hue_num_s2[NUM_W-1:QUO_W] < hue_den_s2))
	`RHC_ASSERT_ALWAYS(a_sat_div_range, !vld_s2 || (sat_num_s2[NUM_W-1:QUO_W] < sat_den_s2))
	// results stay within their documented ranges
	`RHC_ASSERT_IMPL(a_hue_out_range, m_tvalid, hue_q < QUO_W'(23040))
	`RHC_ASSERT_IMPL(a_sl_out_range, m_tvalid,
		(sat_q <= QUO_W'(SAT_SCALE)) && (light_q <= QUO_W'(SAT_SCALE)))

endmodule
